[sv/dmc_pkg.sv]
// Shared types and constants for the direct-mapped write-through cache core.
// Depends on nothing; used by every other file through scoped names.
`default_nettype none

package dmc_pkg;

    // Fixed field widths of the request and result channels
    localparam int ADDR_W = 12;
    localparam int WORD_W = 32;
    localparam int TAG_W  = 12;
    localparam int LINE_W = 10;
    localparam int OFFS_W = 4;
    localparam int LOG_W  = 5;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_LOG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_LOG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG = 2'd2;

    localparam int MEM_LOG_REG_W   = 4;
    localparam int CACHE_LOG_REG_W = 4;
    localparam int BLOCK_LOG_REG_W = 3;

    localparam logic [MEM_LOG_REG_W-1:0]   RST_MEM_LOG   = 4'd12;
    localparam logic [CACHE_LOG_REG_W-1:0] RST_CACHE_LOG = 4'd10;
    localparam logic [BLOCK_LOG_REG_W-1:0] RST_BLOCK_LOG = 3'd2;

    // Smallest memory size log2 the core will run with
    localparam int MEM_MIN_LOG = 4;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_step;
        logic tag_rd;
        logic tag_chk;
        logic tag_wr;
        logic fill_start;
        logic fill_step;
        logic wr;
        logic data_rd;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic oor;
        logic hit;
        logic is_write;
        logic fill_done;
        logic sweep_last;
    } t_status;

    // Elaboration-time helper for parameter-derived sizes
    function automatic int f_floor_log2(input int x);
        int n;
        int v;
        n = 0;
        v = x;
        while (v > 1) begin
            v = v >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[sv/dmc_ctrl.sv]
// Sequencing state machine of the cache core: lookup, fill, update, result.
// Depends on dmc_pkg for the command and status structs.
`default_nettype none

module dmc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire logic             i_cfg_wr,
    input  wire dmc_pkg::t_status i_status,
    output dmc_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_TAG  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_TAG;
                end
            end
            S_TAG: begin
                if (i_status.oor) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.tag_rd = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.tag_chk = 1'b1;
                if (i_status.hit) begin
                    n_state = i_status.is_write ? S_WR : S_RD;
                end else begin
                    o_cmd.tag_wr     = 1'b1;
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_done) begin
                    n_state = i_status.is_write ? S_WR : S_RD;
                end
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DONE;
            end
            S_RD: begin
                o_cmd.data_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
        // size change restarts the sweep
        if (i_cfg_wr) begin
            o_cmd             = '0;
            o_cmd.sweep_start = 1'b1;
            n_state           = S_CLR;
        end
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/dmc_dpath.sv]
// Datapath of the cache core: main memory, tag and data stores, counters,
// address split and result register. Depends on dmc_pkg.
`default_nettype none

module dmc_dpath #(
    parameter int MEM_DEPTH   = 4096,
    parameter int CACHE_DEPTH = 1024,
    parameter int MAX_BLOCK   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dmc_pkg::t_cmd                       i_cmd,
    output dmc_pkg::t_status                         o_status,
    input  wire logic [dmc_pkg::MEM_LOG_REG_W-1:0]   i_cfg_mem,
    input  wire logic [dmc_pkg::CACHE_LOG_REG_W-1:0] i_cfg_cache,
    input  wire logic [dmc_pkg::BLOCK_LOG_REG_W-1:0] i_cfg_block,
    input  wire logic                                i_func,
    input  wire logic [dmc_pkg::ADDR_W-1:0]          i_address,
    input  wire logic [dmc_pkg::WORD_W-1:0]          i_write_data,
    output logic                                     o_hit,
    output logic [dmc_pkg::WORD_W-1:0]               o_data_word,
    output logic [dmc_pkg::TAG_W-1:0]                o_tag_value,
    output logic [dmc_pkg::LINE_W-1:0]               o_line_number,
    output logic [dmc_pkg::OFFS_W-1:0]               o_word_offset,
    output logic                                     o_out_of_range
);

    localparam int AW        = dmc_pkg::ADDR_W;
    localparam int WW        = dmc_pkg::WORD_W;
    localparam int LW        = dmc_pkg::LOG_W;
    localparam int TSW       = dmc_pkg::TAG_W + 1;
    localparam int MEM_LOG   = dmc_pkg::f_floor_log2(MEM_DEPTH);
    localparam int CACHE_LOG = dmc_pkg::f_floor_log2(CACHE_DEPTH);
    localparam int BLOCK_LOG = dmc_pkg::f_floor_log2(MAX_BLOCK);
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int CIW       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int FW        = BLOCK_LOG + 1;
    localparam int CW        = MEM_AW + 1;

    // effective sizes
    logic [LW-1:0] m_sat, eff_mem, eff_cache, eff_block;

    always_comb begin
        m_sat = LW'(i_cfg_mem);
        if (m_sat < LW'(dmc_pkg::MEM_MIN_LOG)) begin
            m_sat = LW'(dmc_pkg::MEM_MIN_LOG);
        end
        eff_mem = (m_sat < LW'(MEM_LOG)) ? m_sat : LW'(MEM_LOG);
        eff_cache = LW'(i_cfg_cache);
        if (eff_cache > LW'(CACHE_LOG)) begin
            eff_cache = LW'(CACHE_LOG);
        end
        if (eff_cache > eff_mem) begin
            eff_cache = eff_mem;
        end
        eff_block = LW'(i_cfg_block);
        if (eff_block > LW'(BLOCK_LOG)) begin
            eff_block = LW'(BLOCK_LOG);
        end
        if (eff_block > eff_cache) begin
            eff_block = eff_cache;
        end
    end

    // request registers
    logic          r_func;
    logic [AW-1:0] r_addr;
    logic [WW-1:0] r_wdata;
    logic          r_hit;

    // address split
    logic [AW-1:0] c_mask, b_mask, tag, cidx, line, word, base, cbase;
    logic          oor;

    assign c_mask = (AW'(1) << eff_cache) - AW'(1);
    assign b_mask = (AW'(1) << eff_block) - AW'(1);
    assign tag    = r_addr >> eff_cache;
    assign cidx   = r_addr & c_mask;
    assign line   = cidx >> eff_block;
    assign word   = r_addr & b_mask;
    assign base   = r_addr & ~b_mask;
    assign cbase  = cidx & ~b_mask;
    assign oor    = ((r_addr >> eff_mem) != '0);

    // counters
    logic [MEM_AW-1:0] r_sweep;
    logic [FW-1:0]     r_fill_cnt, r_fill_wcnt, blk_size;
    logic              r_fill_wen;
    logic              fill_more;

    assign blk_size  = FW'(1) << eff_block;
    assign fill_more = (r_fill_cnt < blk_size);

    // store indexes
    logic [MEM_AW+AW-1:0] addr_x, fill_x;
    logic [CIW+AW-1:0]    cidx_x, line_x, fillw_x;
    logic [CIW+MEM_AW-1:0] sweep_x;
    logic [MEM_AW-1:0]    mem_idx, fill_idx;
    logic [CIW-1:0]       cidx_idx, line_idx, fillw_idx, sweep_tidx;

    assign addr_x     = {{MEM_AW{1'b0}}, r_addr};
    assign fill_x     = {{MEM_AW{1'b0}}, base + AW'(r_fill_cnt)};
    assign cidx_x     = {{CIW{1'b0}}, cidx};
    assign line_x     = {{CIW{1'b0}}, line};
    assign fillw_x    = {{CIW{1'b0}}, cbase + AW'(r_fill_wcnt)};
    assign sweep_x    = {{CIW{1'b0}}, r_sweep};
    assign mem_idx    = addr_x[MEM_AW-1:0];
    assign fill_idx   = fill_x[MEM_AW-1:0];
    assign cidx_idx   = cidx_x[CIW-1:0];
    assign line_idx   = line_x[CIW-1:0];
    assign fillw_idx  = fillw_x[CIW-1:0];
    assign sweep_tidx = sweep_x[CIW-1:0];

    // sweep value: size - i below the memory size, zero above
    logic [CW-1:0] mem_size, sweep_ext;
    logic [WW-1:0] sweep_val;
    logic          sweep_in_cache;

    assign mem_size       = CW'(1) << eff_mem;
    assign sweep_ext      = {1'b0, r_sweep};
    assign sweep_val      = (sweep_ext < mem_size) ? WW'(mem_size - sweep_ext) : '0;
    assign sweep_in_cache = ({{(32-MEM_AW){1'b0}}, r_sweep} < 32'(CACHE_DEPTH));

    // stores
    logic [WW-1:0]  r_main_mem  [MEM_DEPTH];
    logic [WW-1:0]  r_cache_mem [CACHE_DEPTH];
    logic [TSW-1:0] r_tag_mem   [CACHE_DEPTH];
    logic [WW-1:0]  r_mem_q, r_cdata_q;
    logic [TSW-1:0] r_tag_q;

    logic              mem_we, cache_we, tag_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [CIW-1:0]    cache_waddr, tag_waddr;
    logic [WW-1:0]     mem_wdata, cache_wdata;
    logic [TSW-1:0]    tag_wdata;

    always_comb begin
        mem_we      = i_cmd.sweep_step | i_cmd.wr;
        mem_waddr   = i_cmd.sweep_step ? r_sweep : mem_idx;
        mem_wdata   = i_cmd.sweep_step ? sweep_val : r_wdata;
        cache_we    = r_fill_wen | i_cmd.wr;
        cache_waddr = r_fill_wen ? fillw_idx : cidx_idx;
        cache_wdata = r_fill_wen ? r_mem_q : r_wdata;
        tag_we      = i_cmd.tag_wr | (i_cmd.sweep_step & sweep_in_cache);
        tag_waddr   = i_cmd.sweep_step ? sweep_tidx : line_idx;
        tag_wdata   = i_cmd.sweep_step ? '0 : {1'b1, tag};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_main_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.fill_step && fill_more) begin
            r_mem_q <= r_main_mem[fill_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cache_we) begin
            r_cache_mem[cache_waddr] <= cache_wdata;
        end
        if (i_cmd.data_rd) begin
            r_cdata_q <= r_cache_mem[cidx_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        if (i_cmd.tag_rd) begin
            r_tag_q <= r_tag_mem[line_idx];
        end
    end

    logic hit_now;
    assign hit_now = r_tag_q[TSW-1] && (r_tag_q[TSW-2:0] == tag);

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= '0;
            r_fill_cnt <= '0;
            r_fill_wen <= 1'b0;
        end else begin
            if (i_cmd.sweep_start) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + MEM_AW'(1);
            end
            if (i_cmd.fill_start) begin
                r_fill_cnt <= '0;
            end else if (i_cmd.fill_step && fill_more) begin
                r_fill_cnt <= r_fill_cnt + FW'(1);
            end
            r_fill_wen <= i_cmd.fill_step & fill_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_wcnt <= r_fill_cnt;
    end

    // request capture and hit flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.accept) begin
            r_hit <= 1'b0;
        end else if (i_cmd.tag_chk) begin
            r_hit <= hit_now;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit          <= r_hit & ~oor;
            o_data_word    <= oor ? '0 : (r_func ? r_wdata : r_cdata_q);
            o_tag_value    <= tag;
            o_line_number  <= line[dmc_pkg::LINE_W-1:0];
            o_word_offset  <= word[dmc_pkg::OFFS_W-1:0];
            o_out_of_range <= oor;
        end
    end

    assign o_status.oor        = oor;
    assign o_status.hit        = hit_now;
    assign o_status.is_write   = r_func;
    assign o_status.fill_done  = ~fill_more;
    assign o_status.sweep_last = (r_sweep == MEM_AW'(MEM_DEPTH - 1));

endmodule

`default_nettype wire

[sv/direct_mapped_write_through_cache_core.sv]
// Top level of the direct-mapped write-through cache core: configuration
// registers and port, controller and datapath. Depends on dmc_pkg, dmc_ctrl, dmc_dpath.
`default_nettype none

// Direct-mapped, write-through, write-allocate cache in front of a word-addressed
// main memory, both held on chip. Each request is one read (func 0) or write
// (func 1) of one word address and yields exactly one result: hit flag, data
// word (word read, or word written), tag, line, word offset and an
// out-of-range flag. Requests at or beyond the memory size return hit 0 and
// data 0 and change nothing. Sizes are set as log2 values through the APB
// port (memory at 0x0, cache at 0x4, block at 0x8) and saturate to the
// configured depths. A write to any size register invalidates every line and
// reloads main memory with entry i = size - i; requests are stalled during
// this sweep and during the one after reset. On a miss the block fill reads
// one word per cycle through the single main memory read port. One request
// is in flight at a time; a finished result sits in the output register while
// the next request is taken. Depths are meant to be powers of two.

module direct_mapped_write_through_cache_core #(
    parameter int MEM_DEPTH   = 4096,
    parameter int CACHE_DEPTH = 1024,
    parameter int MAX_BLOCK   = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_func,
    input  wire logic [dmc_pkg::ADDR_W-1:0]        i_address,
    input  wire logic signed [dmc_pkg::WORD_W-1:0] i_write_data,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_hit,
    output logic signed [dmc_pkg::WORD_W-1:0]      o_data_word,
    output logic [dmc_pkg::TAG_W-1:0]              o_tag_value,
    output logic [dmc_pkg::LINE_W-1:0]             o_line_number,
    output logic [dmc_pkg::OFFS_W-1:0]             o_word_offset,
    output logic                                   o_out_of_range,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dmc_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [dmc_pkg::PDATA_W-1:0]       pwdata,
    output logic [dmc_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);

    // Size registers. Word-aligned decode on paddr[3:2]; low bits are ignored.
    logic [dmc_pkg::MEM_LOG_REG_W-1:0]   r_cfg_mem,   n_cfg_mem;
    logic [dmc_pkg::CACHE_LOG_REG_W-1:0] r_cfg_cache, n_cfg_cache;
    logic [dmc_pkg::BLOCK_LOG_REG_W-1:0] r_cfg_block, n_cfg_block;
    logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_idx;
    logic                                cfg_wr;
    logic                                cfg_hit;

    assign cfg_idx = paddr[dmc_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg_mem   = r_cfg_mem;
        n_cfg_cache = r_cfg_cache;
        n_cfg_block = r_cfg_block;
        cfg_hit     = 1'b0;
        if (cfg_wr) begin
            case (cfg_idx)
                dmc_pkg::REG_MEM_LOG: begin
                    n_cfg_mem = pwdata[dmc_pkg::MEM_LOG_REG_W-1:0];
                    cfg_hit   = 1'b1;
                end
                dmc_pkg::REG_CACHE_LOG: begin
                    n_cfg_cache = pwdata[dmc_pkg::CACHE_LOG_REG_W-1:0];
                    cfg_hit     = 1'b1;
                end
                dmc_pkg::REG_BLOCK_LOG: begin
                    n_cfg_block = pwdata[dmc_pkg::BLOCK_LOG_REG_W-1:0];
                    cfg_hit     = 1'b1;
                end
                default: begin
                    // unmapped: no effect, no sweep
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mem   <= dmc_pkg::RST_MEM_LOG;
            r_cfg_cache <= dmc_pkg::RST_CACHE_LOG;
            r_cfg_block <= dmc_pkg::RST_BLOCK_LOG;
        end else begin
            r_cfg_mem   <= n_cfg_mem;
            r_cfg_cache <= n_cfg_cache;
            r_cfg_block <= n_cfg_block;
        end
    end

    // read-back, zero-extended
    always_comb begin
        case (cfg_idx)
            dmc_pkg::REG_MEM_LOG:   prdata = dmc_pkg::PDATA_W'(r_cfg_mem);
            dmc_pkg::REG_CACHE_LOG: prdata = dmc_pkg::PDATA_W'(r_cfg_cache);
            dmc_pkg::REG_BLOCK_LOG: prdata = dmc_pkg::PDATA_W'(r_cfg_block);
            default:                prdata = '0;
        endcase
    end

    // controller / datapath
    dmc_pkg::t_cmd    cmd;
    dmc_pkg::t_status status;
    logic [dmc_pkg::WORD_W-1:0] data_word;

    dmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_cfg_wr (cfg_hit),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dmc_dpath #(
        .MEM_DEPTH   (MEM_DEPTH),
        .CACHE_DEPTH (CACHE_DEPTH),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_mem      (r_cfg_mem),
        .i_cfg_cache    (r_cfg_cache),
        .i_cfg_block    (r_cfg_block),
        .i_func         (i_func),
        .i_address      (i_address),
        .i_write_data   ($unsigned(i_write_data)),
        .o_hit          (o_hit),
        .o_data_word    (data_word),
        .o_tag_value    (o_tag_value),
        .o_line_number  (o_line_number),
        .o_word_offset  (o_word_offset),
        .o_out_of_range (o_out_of_range)
    );

    assign o_data_word = $signed(data_word);

endmodule

`default_nettype wire
